FILE: rtl/tsla_pkg.sv
// ----------------------------------------------------------------------------
// tsla_pkg
// Shared types and constants of the triangle surface load block.
// ----------------------------------------------------------------------------
package tsla_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int INDEX_BITS_DEF = 16;
    localparam int STEP_W         = 5;
    localparam int FORCE_STEPS    = 3;
    localparam int CROSS_OPS      = 6;
    localparam int SQ_STEPS       = 3;
    localparam int SQRT_ITERS     = 32;
    localparam int DIV_STEPS      = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FORCE,
        ST_HOLD,
        ST_EDGE,
        ST_CROSS,
        ST_SQ,
        ST_SQRT,
        ST_AREA,
        ST_LD_S,
        ST_LD_M0,
        ST_LD_M1,
        ST_LD_ACC,
        ST_DIV,
        ST_LD_FIN,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FORCE,
        OP_HOLD,
        OP_EDGE,
        OP_CROSS,
        OP_SQ,
        OP_SQRT,
        OP_AREA,
        OP_LD_S,
        OP_LD_M0,
        OP_LD_M1,
        OP_LD_ACC,
        OP_DIV,
        OP_LD_FIN,
        OP_ROW
    } dp_op_t;

    typedef struct packed {
        logic              cap;
        dp_op_t            op;
        logic [STEP_W-1:0] step;
        logic              slot;
        logic              last;
    } dp_cmd_t;

endpackage

FILE: rtl/tsla_ctrl.sv
// ----------------------------------------------------------------------------
// tsla_ctrl
// Sequencer: walks the datapath through force, area and load steps.
// ----------------------------------------------------------------------------
module tsla_ctrl
    import tsla_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    ctl_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        vcnt_reg, vcnt_next;
    logic [1:0]        vtx_reg, vtx_next;
    logic [1:0]        comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            vcnt_reg  <= '0;
            vtx_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            vcnt_reg  <= vcnt_next;
            vtx_reg   <= vtx_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        vcnt_next  = vcnt_reg;
        vtx_next   = vtx_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    step_next  = '0;
                    state_next = ST_FORCE;
                end
            end
            ST_FORCE:
            begin
                cmd.op = OP_FORCE;
                if (step_reg == STEP_W'(FORCE_STEPS))
                begin
                    step_next  = '0;
                    state_next = (vcnt_reg < 2'd2) ? ST_HOLD : ST_EDGE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_HOLD:
            begin
                cmd.op     = OP_HOLD;
                cmd.slot   = vcnt_reg[0];
                vcnt_next  = vcnt_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_EDGE:
            begin
                cmd.op     = OP_EDGE;
                step_next  = '0;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                cmd.op = OP_CROSS;
                if (step_reg == STEP_W'(CROSS_OPS))
                begin
                    step_next  = '0;
                    vcnt_next  = '0;
                    state_next = ST_SQ;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_SQ:
            begin
                cmd.op = OP_SQ;
                if (step_reg == STEP_W'(SQ_STEPS))
                begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (step_reg == STEP_W'(SQRT_ITERS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_AREA;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_AREA:
            begin
                cmd.op     = OP_AREA;
                vtx_next   = '0;
                comp_next  = '0;
                state_next = ST_LD_S;
            end
            ST_LD_S:
            begin
                cmd.op     = OP_LD_S;
                state_next = ST_LD_M0;
            end
            ST_LD_M0:
            begin
                cmd.op     = OP_LD_M0;
                state_next = ST_LD_M1;
            end
            ST_LD_M1:
            begin
                cmd.op     = OP_LD_M1;
                state_next = ST_LD_ACC;
            end
            ST_LD_ACC:
            begin
                cmd.op     = OP_LD_ACC;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_LD_FIN;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_LD_FIN:
            begin
                cmd.op   = OP_LD_FIN;
                cmd.last = (vtx_reg == 2'd2);
                if (comp_reg == 2'd2)
                begin
                    comp_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_LD_S;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (vtx_reg == 2'd2)
                    begin
                        vtx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.op     = OP_ROW;
                        vtx_next   = vtx_reg + 1'b1;
                        state_next = ST_LD_S;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/tsla_dp.sv
// ----------------------------------------------------------------------------
// tsla_dp
// Datapath: shared 33x33 multiplier, isqrt unit, divide-by-3 unit, vertex regs.
// ----------------------------------------------------------------------------
module tsla_dp
    import tsla_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                   clk,
    input  dp_cmd_t                cmd,
    input  logic signed [31:0]     pos_x,
    input  logic signed [31:0]     pos_y,
    input  logic signed [31:0]     pos_z,
    input  logic signed [31:0]     traction_x,
    input  logic signed [31:0]     traction_y,
    input  logic signed [31:0]     traction_z,
    input  logic signed [31:0]     pressure,
    input  logic signed [31:0]     normal_x,
    input  logic signed [31:0]     normal_y,
    input  logic signed [31:0]     normal_z,
    input  logic [INDEX_BITS-1:0]  point_index,
    output logic [INDEX_BITS-1:0]  out_index,
    output logic signed [31:0]     load_x,
    output logic signed [31:0]     load_y,
    output logic signed [31:0]     load_z,
    output logic                   tri_last
);

    localparam logic [65:0] SAT_LIM = 66'd6442450947;  // 3*(2^31+1)

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // eight restoring steps of a divide by 3, returns {quotient byte, remainder}
    function automatic logic [9:0] div3_8(input logic [1:0] r_in, input logic [7:0] d);
        logic [1:0] r;
        logic [2:0] t;
        logic [7:0] q;
        r = r_in;
        q = '0;
        for (int b = 7; b >= 0; b--)
        begin
            t = {r, d[b]};
            if (t >= 3'd3)
            begin
                q[b] = 1'b1;
                r    = 2'(t - 3'd3);
            end
            else
            begin
                q[b] = 1'b0;
                r    = t[1:0];
            end
        end
        return {q, r};
    endfunction

    logic signed [31:0]    cur_pos_reg [3], cur_pos_next [3];
    logic signed [31:0]    cur_tr_reg [3], cur_tr_next [3];
    logic signed [31:0]    cur_n_reg [3], cur_n_next [3];
    logic signed [31:0]    cur_pr_reg, cur_pr_next;
    logic [INDEX_BITS-1:0] cur_idx_reg, cur_idx_next;
    logic signed [31:0]    cur_f_reg [3], cur_f_next [3];
    logic signed [31:0]    hp_reg [2][3], hp_next [2][3];
    logic signed [31:0]    vf_reg [3][3], vf_next [3][3];
    logic [INDEX_BITS-1:0] vidx_reg [3], vidx_next [3];
    logic signed [31:0]    e1_reg [3], e1_next [3];
    logic signed [31:0]    e2_reg [3], e2_next [3];
    logic signed [65:0]    c_reg [3], c_next [3];
    logic signed [65:0]    prod_reg, prod_next;
    logic signed [65:0]    hold_reg, hold_next;
    logic [63:0]           sum_reg, sum_next;
    logic                  ovf_reg, ovf_next;
    logic [63:0]           n_reg, n_next;
    logic [63:0]           root_reg, root_next;
    logic [63:0]           bit_reg, bit_next;
    logic [30:0]           area_reg, area_next;
    logic                  neg_reg, neg_next;
    logic [34:0]           smag_reg, smag_next;
    logic [65:0]           acc_reg, acc_next;
    logic                  big_reg, big_next;
    logic [39:0]           dv_reg, dv_next;
    logic [1:0]            rem_reg, rem_next;
    logic [39:0]           q_reg, q_next;
    logic signed [31:0]    load_reg [3], load_next [3];
    logic [INDEX_BITS-1:0] oidx_reg, oidx_next;
    logic                  last_reg, last_next;

    logic signed [32:0] mul_a, mul_b;
    logic [1:0]         fj;
    logic [2:0]         xj;
    logic [1:0]         sj;
    logic signed [65:0] pn, diff;
    logic [65:0]        cmag;
    logic [64:0]        sum65;
    logic [63:0]        n_c, root_c, bit_c, sq_t;
    logic signed [34:0] s_val;
    logic [65:0]        tot, yv;
    logic [9:0]         dres;
    logic signed [31:0] res;

    always_ff @(posedge clk)
    begin
        cur_pos_reg <= cur_pos_next;
        cur_tr_reg  <= cur_tr_next;
        cur_n_reg   <= cur_n_next;
        cur_pr_reg  <= cur_pr_next;
        cur_idx_reg <= cur_idx_next;
        cur_f_reg   <= cur_f_next;
        hp_reg      <= hp_next;
        vf_reg      <= vf_next;
        vidx_reg    <= vidx_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        c_reg       <= c_next;
        prod_reg    <= prod_next;
        hold_reg    <= hold_next;
        sum_reg     <= sum_next;
        ovf_reg     <= ovf_next;
        n_reg       <= n_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        area_reg    <= area_next;
        neg_reg     <= neg_next;
        smag_reg    <= smag_next;
        acc_reg     <= acc_next;
        big_reg     <= big_next;
        dv_reg      <= dv_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        load_reg    <= load_next;
        oidx_reg    <= oidx_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        cur_pos_next = cur_pos_reg;
        cur_tr_next  = cur_tr_reg;
        cur_n_next   = cur_n_reg;
        cur_pr_next  = cur_pr_reg;
        cur_idx_next = cur_idx_reg;
        cur_f_next   = cur_f_reg;
        hp_next      = hp_reg;
        vf_next      = vf_reg;
        vidx_next    = vidx_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        c_next       = c_reg;
        hold_next    = hold_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        area_next    = area_reg;
        neg_next     = neg_reg;
        smag_next    = smag_reg;
        acc_next     = acc_reg;
        big_next     = big_reg;
        dv_next      = dv_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        load_next    = load_reg;
        oidx_next    = oidx_reg;
        last_next    = last_reg;

        mul_a  = '0;
        mul_b  = '0;
        fj     = 2'(cmd.step - 1'b1);
        xj     = 3'(cmd.step - 1'b1);
        sj     = cmd.step[1:0];
        pn     = prod_reg >>> FRAC_BITS;
        diff   = '0;
        cmag   = '0;
        sum65  = {1'b0, sum_reg} + {1'b0, prod_reg[63:0]};
        n_c    = (cmd.step == '0) ? sum_reg : n_reg;
        root_c = (cmd.step == '0) ? 64'd0 : root_reg;
        bit_c  = (cmd.step == '0) ? (64'd1 << 62) : bit_reg;
        sq_t   = root_c + bit_c;
        s_val  = (35'(vf_reg[0][0]) <<< 1) + 35'(vf_reg[1][0]) + 35'(vf_reg[2][0]);
        tot    = acc_reg + {prod_reg[33:0], 32'd0};
        yv     = tot >> (FRAC_BITS + 2);
        dres   = div3_8(rem_reg, dv_reg[39:32]);
        res    = '0;

        if (cmd.cap)
        begin
            cur_pos_next = '{pos_x, pos_y, pos_z};
            cur_tr_next  = '{traction_x, traction_y, traction_z};
            cur_n_next   = '{normal_x, normal_y, normal_z};
            cur_pr_next  = pressure;
            cur_idx_next = point_index;
        end

        case (cmd.op)
            OP_FORCE:
            begin
                if (cmd.step < STEP_W'(FORCE_STEPS))
                begin
                    mul_a = 33'(cur_pr_reg);
                    mul_b = 33'(cur_n_reg[sj]);
                end
                if (cmd.step != '0)
                    cur_f_next[fj] = sat32(66'(cur_tr_reg[fj]) - pn);
            end
            OP_HOLD:
            begin
                hp_next[cmd.slot]   = cur_pos_reg;
                vf_next[cmd.slot]   = cur_f_reg;
                vidx_next[cmd.slot] = cur_idx_reg;
            end
            OP_EDGE:
            begin
                vf_next[2]   = cur_f_reg;
                vidx_next[2] = cur_idx_reg;
                for (int k = 0; k < 3; k++)
                begin
                    e1_next[k] = sat32(66'(hp_reg[1][k]) - 66'(hp_reg[0][k]));
                    e2_next[k] = sat32(66'(cur_pos_reg[k]) - 66'(hp_reg[0][k]));
                end
            end
            OP_CROSS:
            begin
                case (cmd.step[2:0])
                    3'd0:
                    begin
                        mul_a = 33'(e1_reg[1]);
                        mul_b = 33'(e2_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = 33'(e1_reg[2]);
                        mul_b = 33'(e2_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = 33'(e1_reg[2]);
                        mul_b = 33'(e2_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = 33'(e1_reg[0]);
                        mul_b = 33'(e2_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = 33'(e1_reg[0]);
                        mul_b = 33'(e2_reg[1]);
                    end
                    3'd5:
                    begin
                        mul_a = 33'(e1_reg[1]);
                        mul_b = 33'(e2_reg[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                if (cmd.step != '0)
                begin
                    if (!xj[0])
                        hold_next = prod_reg;
                    else
                    begin
                        diff             = hold_reg - prod_reg;
                        c_next[xj[2:1]]  = diff >>> FRAC_BITS;
                    end
                end
            end
            OP_SQ:
            begin
                ovf_next = (cmd.step == '0) ? 1'b0 : ovf_reg;
                if (cmd.step < STEP_W'(SQ_STEPS))
                begin
                    cmag  = c_reg[sj][65] ? 66'(-c_reg[sj]) : 66'(c_reg[sj]);
                    mul_a = {1'b0, cmag[31:0]};
                    mul_b = {1'b0, cmag[31:0]};
                    if (|cmag[65:32])
                        ovf_next = 1'b1;
                end
                if (cmd.step == '0)
                    sum_next = '0;
                else
                begin
                    sum_next = sum65[63:0];
                    if (sum65[64])
                        ovf_next = 1'b1;
                end
            end
            OP_SQRT:
            begin
                if (n_c >= sq_t)
                begin
                    n_next    = n_c - sq_t;
                    root_next = (root_c >> 1) + bit_c;
                end
                else
                begin
                    n_next    = n_c;
                    root_next = root_c >> 1;
                end
                bit_next = bit_c >> 2;
            end
            OP_AREA:
            begin
                area_next = ovf_reg ? 31'h7fffffff : root_reg[31:1];
            end
            OP_LD_S:
            begin
                neg_next  = s_val[34];
                smag_next = s_val[34] ? 35'(-s_val) : 35'(s_val);
            end
            OP_LD_M0:
            begin
                mul_a = {2'b00, area_reg};
                mul_b = {1'b0, smag_reg[31:0]};
            end
            OP_LD_M1:
            begin
                acc_next = {2'b00, prod_reg[63:0]};
                mul_a    = {2'b00, area_reg};
                mul_b    = {30'd0, smag_reg[34:32]};
            end
            OP_LD_ACC:
            begin
                big_next = (yv >= SAT_LIM);
                dv_next  = yv[39:0];
                rem_next = '0;
                q_next   = '0;
            end
            OP_DIV:
            begin
                q_next   = {q_reg[31:0], dres[9:2]};
                rem_next = dres[1:0];
                dv_next  = {dv_reg[31:0], 8'd0};
            end
            OP_LD_FIN:
            begin
                if (big_reg)
                    res = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
                else if (neg_reg)
                    res = 32'(-q_reg);
                else if (q_reg > 40'd2147483647)
                    res = 32'sh7fffffff;
                else
                    res = q_reg[31:0];
                load_next[0] = load_reg[1];
                load_next[1] = load_reg[2];
                load_next[2] = res;
                for (int r = 0; r < 3; r++)
                begin
                    vf_next[r][0] = vf_reg[r][1];
                    vf_next[r][1] = vf_reg[r][2];
                    vf_next[r][2] = vf_reg[r][0];
                end
                oidx_next = vidx_reg[0];
                last_next = cmd.last;
            end
            OP_ROW:
            begin
                vf_next[0]   = vf_reg[1];
                vf_next[1]   = vf_reg[2];
                vf_next[2]   = vf_reg[0];
                vidx_next[0] = vidx_reg[1];
                vidx_next[1] = vidx_reg[2];
                vidx_next[2] = vidx_reg[0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

    assign out_index = oidx_reg;
    assign load_x    = load_reg[0];
    assign load_y    = load_reg[1];
    assign load_z    = load_reg[2];
    assign tri_last  = last_reg;

endmodule

FILE: rtl/triangle_surface_load_assembly_top.sv
// ----------------------------------------------------------------------------
// triangle_surface_load_assembly_top
// Consistent surface load of a linear boundary triangle, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one vertex per transfer, three
//   transfers per triangle. Each vertex gives f = traction - pressure*normal.
//   Output channel (out_valid / out_stall): three load increments per
//   triangle, vertex 0, 1, 2 order, tri_last set on the third.
// Sequence:
//   Each of the first two vertices runs 3 multiplies through the shared
//   multiplier plus a hold write before the next transfer is taken.
//   The third vertex runs on to the area: force steps, the edges, the
//   cross products, square/sum steps and 32 isqrt iterations. Each load
//   component then takes 2 partial products, an accumulate, a divide by 3 at
//   8 bits per cycle and a saturate; a result holds three components. The
//   shared 33x33 multiplier and the isqrt loop set the time of a triangle.
// Reset: asynchronous rst_n clears the sequencer and the vertex count, so
//   the next transfer starts a new triangle. Held vertex data is not cleared.
// Stall: a result stays on the port until taken; no input is taken while
//   the block works on a vertex or holds results.
// ----------------------------------------------------------------------------
module triangle_surface_load_assembly_top
    import tsla_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // vertex channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic signed [31:0]    traction_x,
    input  logic signed [31:0]    traction_y,
    input  logic signed [31:0]    traction_z,
    input  logic signed [31:0]    pressure,
    input  logic signed [31:0]    normal_x,
    input  logic signed [31:0]    normal_y,
    input  logic signed [31:0]    normal_z,
    input  logic [INDEX_BITS-1:0] point_index,
    // load increment channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_BITS-1:0] out_index,
    output logic signed [31:0]    load_x,
    output logic signed [31:0]    load_y,
    output logic signed [31:0]    load_z,
    output logic                  tri_last
);

    dp_cmd_t cmd;

    // sequencer: owns the handshakes and all step counters
    tsla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: vertex registers, shared multiplier, isqrt and divide units
    tsla_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .traction_x  (traction_x),
        .traction_y  (traction_y),
        .traction_z  (traction_z),
        .pressure    (pressure),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .point_index (point_index),
        .out_index   (out_index),
        .load_x      (load_x),
        .load_y      (load_y),
        .load_z      (load_z),
        .tri_last    (tri_last)
    );

endmodule

FILE: rtl/tsla_checker.sv
// ----------------------------------------------------------------------------
// tsla_checker
// Port-level checks of the triangle surface load block, bound to the top.
// ----------------------------------------------------------------------------
module tsla_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        tri_last,
    input logic [31:0] load_x,
    input logic [31:0] load_y,
    input logic [31:0] load_z
);

    // no vertex is taken while results are pending
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("vertex accepted while a result is pending");

    // in the cycle after a vertex transfer the block is busy
    a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second vertex taken back to back");

    // a triangle is not done until its last increment leaves
    a_mid_tri: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !tri_last) |=> in_stall)
        else $error("input reopened in the middle of a triangle");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(load_x) && $stable(load_y) && $stable(load_z)))
        else $error("stalled result changed");

endmodule

bind triangle_surface_load_assembly_top tsla_checker u_tsla_checker (.*);

FILE: bench/tsla_load_checker.sv
// ----------------------------------------------------------------------------
// tsla_load_checker
// Watches both channels, predicts the load increments of each triangle and
// compares every output transfer field by field against the oldest one.
// ----------------------------------------------------------------------------
module tsla_load_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] traction_x,
    input  logic signed [31:0] traction_y,
    input  logic signed [31:0] traction_z,
    input  logic signed [31:0] pressure,
    input  logic signed [31:0] normal_x,
    input  logic signed [31:0] normal_y,
    input  logic signed [31:0] normal_z,
    input  logic [15:0]        point_index,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [15:0]        out_index,
    input  logic signed [31:0] load_x,
    input  logic signed [31:0] load_y,
    input  logic signed [31:0] load_z,
    input  logic               tri_last,
    output int                 fail_count,
    output int                 pending_loads
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;

    typedef struct packed {
        logic [15:0]        idx;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] lz;
        logic               last;
    } load_t;

    load_t             load_q[$];
    logic signed [63:0] vtx_pos[3][3];
    logic signed [63:0] vtx_force[3][3];
    logic [15:0]        vtx_idx[3];
    int                 vtx_cnt;

    function automatic logic signed [63:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 64'sd2147483647;
        if (v < -128'sd2147483648) return -64'sd2147483648;
        return v[63:0];
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] area_of();
        logic signed [127:0] e1[3];
        logic signed [127:0] e2[3];
        logic signed [127:0] c[3];
        logic [127:0]        sum;
        logic [127:0]        m;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = clamp32(128'(vtx_pos[1][i]) - 128'(vtx_pos[0][i]));
            e2[i] = clamp32(128'(vtx_pos[2][i]) - 128'(vtx_pos[0][i]));
        end
        // arithmetic shift on signed gives floor
        c[0] = (e1[1] * e2[2] - e1[2] * e2[1]) >>> FB;
        c[1] = (e1[2] * e2[0] - e1[0] * e2[2]) >>> FB;
        c[2] = (e1[0] * e2[1] - e1[1] * e2[0]) >>> FB;
        for (int i = 0; i < 3; i++)
        begin
            m = c[i] < 0 ? -c[i] : c[i];
            if (m >= (128'd1 << 32)) return 64'sd2147483647;
            sum = sum + m * m;
            if (sum >= (128'd1 << 64)) return 64'sd2147483647;
        end
        return $signed(isqrt(sum[63:0]) >> 1);
    endfunction

    function automatic logic signed [31:0] load_comp(input logic signed [63:0] area,
        input logic signed [63:0] own, input logic signed [63:0] o1,
        input logic signed [63:0] o2);
        logic signed [127:0] s;
        logic [127:0]        m;
        logic [127:0]        res;
        s = 2 * 128'(own) + 128'(o1) + 128'(o2);
        m = s < 0 ? -s : s;
        res = (128'(area) * m) / (128'd12 << FB);
        if (s < 0)
            return res > (128'd1 << 31) ? 32'sh80000000 : 32'(-res);
        return res > 128'd2147483647 ? 32'sh7fffffff : 32'(res);
    endfunction

    assign pending_loads = load_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [127:0] pn;
        logic signed [31:0]  tr[3];
        logic signed [31:0]  nr[3];
        logic signed [63:0]  ar;
        load_t               exp_l;
        load_t               got;
        int                  a;
        int                  b;
        if (!rst_n)
        begin
            vtx_cnt    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tr = '{traction_x, traction_y, traction_z};
                nr = '{normal_x, normal_y, normal_z};
                for (int i = 0; i < 3; i++)
                begin
                    pn = (128'(pressure) * 128'(nr[i])) >>> FB;
                    vtx_force[vtx_cnt][i] = clamp32(128'(tr[i]) - pn);
                end
                vtx_pos[vtx_cnt] = '{64'(pos_x), 64'(pos_y), 64'(pos_z)};
                vtx_idx[vtx_cnt] = point_index;
                if (vtx_cnt < 2)
                    vtx_cnt <= vtx_cnt + 1;
                else
                begin
                    ar = area_of();
                    for (int k = 0; k < 3; k++)
                    begin
                        a = (k + 1) % 3;
                        b = (k + 2) % 3;
                        exp_l.idx  = vtx_idx[k];
                        exp_l.lx   = load_comp(ar, vtx_force[k][0], vtx_force[a][0],
                                               vtx_force[b][0]);
                        exp_l.ly   = load_comp(ar, vtx_force[k][1], vtx_force[a][1],
                                               vtx_force[b][1]);
                        exp_l.lz   = load_comp(ar, vtx_force[k][2], vtx_force[a][2],
                                               vtx_force[b][2]);
                        exp_l.last = (k == 2);
                        load_q.push_back(exp_l);
                    end
                    vtx_cnt <= 0;
                end
            end
            if (out_valid && !out_stall)
            begin
                got = '{out_index, load_x, load_y, load_z, tri_last};
                if (load_q.size() == 0)
                begin
                    $display("%0t: unexpected load transfer, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_l = load_q.pop_front();
                    if (got !== exp_l)
                    begin
                        $display("%0t: load mismatch, expected idx %h x %h y %h z %h last %b",
                                 $time, exp_l.idx, exp_l.lx, exp_l.ly, exp_l.lz, exp_l.last);
                        $display("%0t:                actual idx %h x %h y %h z %h last %b",
                                 $time, got.idx, got.lx, got.ly, got.lz, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/triangle_surface_load_assembly_top_test.sv
// ----------------------------------------------------------------------------
// triangle_surface_load_assembly_top_test
// Drives vertex transfers into the surface load block with random gaps and
// output stalls; the checker predicts and compares, this module gives the
// verdict.
// ----------------------------------------------------------------------------
module triangle_surface_load_assembly_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 310;
    localparam int CYCLE_LIMIT  = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] traction_x, traction_y, traction_z;
    logic signed [31:0] pressure;
    logic signed [31:0] normal_x, normal_y, normal_z;
    logic [15:0]        point_index;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        out_index;
    logic signed [31:0] load_x, load_y, load_z;
    logic               tri_last;
    int                 fail_count;
    int                 pending_loads;
    int                 cycle_count;
    bit                 calm;         // long stretch with no idling

    triangle_surface_load_assembly_top dut (.*);

    tsla_load_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver stalls about 10% of cycles except during the calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 10);

    function automatic logic signed [31:0] rand_val(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return $signed($urandom_range(65536 * 8)) - 32'sd262144;
            default: return $signed($urandom_range(65536 * 200)) - 32'sd6553600;
        endcase
    endfunction

    // One vertex transfer; valid stays up into the next transfer unless an
    // idle cycle comes first.
    task automatic send_vertex(input logic signed [31:0] p[3],
                               input logic signed [31:0] t[3],
                               input logic signed [31:0] pr,
                               input logic signed [31:0] n[3],
                               input logic [15:0] idx);
        while (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pos_x       <= p[0];
        pos_y       <= p[1];
        pos_z       <= p[2];
        traction_x  <= t[0];
        traction_y  <= t[1];
        traction_z  <= t[2];
        pressure    <= pr;
        normal_x    <= n[0];
        normal_y    <= n[1];
        normal_z    <= n[2];
        point_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random(input int mode);
        logic signed [31:0] p[3], t[3], n[3];
        int m;
        for (int i = 0; i < 3; i++)
        begin
            m = (mode < 0) ? $urandom_range(4) : mode;
            p[i] = rand_val(m);
            t[i] = rand_val((mode < 0) ? $urandom_range(4) : mode);
            n[i] = rand_val((mode < 0) ? $urandom_range(4) : mode);
        end
        send_vertex(p, t, rand_val((mode < 0) ? $urandom_range(4) : mode), n,
                    16'($urandom));
    endtask

    initial
    begin
        logic signed [31:0] z3[3];
        logic signed [31:0] p0[3], p1[3], p2[3], t[3], n[3];
        cycle_count = 0;
        calm        = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        pos_x = 0; pos_y = 0; pos_z = 0;
        traction_x = 0; traction_y = 0; traction_z = 0;
        pressure = 0; normal_x = 0; normal_y = 0; normal_z = 0;
        point_index = 0;
        z3 = '{0, 0, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unit right triangle, unit pressure along the normal
        p0 = '{0, 0, 0};
        p1 = '{32'sh10000, 0, 0};
        p2 = '{0, 32'sh10000, 0};
        t  = '{32'sh20000, -32'sh10000, 32'sh8000};
        n  = '{0, 0, 32'sh10000};
        send_vertex(p0, t, 32'sh10000, n, 16'h0000);
        send_vertex(p1, t, 32'sh10000, n, 16'hffff);
        send_vertex(p2, t, -32'sh10000, n, 16'h1234);
        // Degenerate triangle: collinear points, area zero
        send_vertex(p0, t, 0, z3, 16'd1);
        send_vertex(p0, t, 0, z3, 16'd2);
        send_vertex(p1, t, 0, z3, 16'd3);
        // Extremes of every field: saturating force on coincident points
        for (int k = 1; k <= 2; k++)
            repeat (3) send_random(k);
        // Mixed extremes
        repeat (6) send_random(-1);

        // Random part; a calm stretch in the middle
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 120 && i < 180);
            if ($urandom_range(9) == 0)
                send_random(-1);
            else
                send_random($urandom_range(3, 4));
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_loads != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: triangle_surface_load_assembly_top.f
rtl/tsla_pkg.sv
rtl/tsla_ctrl.sv
rtl/tsla_dp.sv
rtl/triangle_surface_load_assembly_top.sv
rtl/tsla_checker.sv
bench/tsla_load_checker.sv
bench/triangle_surface_load_assembly_top_test.sv
